// ===== rtl/core/rau_pkg.sv =====
// Package for the rational arithmetic unit.
// Holds opcode codes, internal widths and default parameter values; no dependencies.
package rau_pkg;

  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int RAW_W             = 64;
  localparam int RES_W             = 33;
  localparam int OP_W              = 3;
  localparam int CNT_W             = $clog2(RAW_W);

  localparam logic [OP_W-1:0] OP_ADD = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV = 3'd3;
  localparam logic [OP_W-1:0] OP_CMP = 3'd4;

endpackage

// ===== rtl/core/rau_req_if.sv =====
// Request channel of the rational arithmetic unit: opcode and two fractions.
// Depends on rau_pkg for the opcode width.
interface rau_req_if #(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
);
  logic                              valid;
  logic                              ready;
  logic [rau_pkg::OP_W-1:0]          req_type;
  logic signed [OPERAND_WIDTH-1:0]   a_num;
  logic signed [OPERAND_WIDTH-1:0]   a_den;
  logic signed [OPERAND_WIDTH-1:0]   b_num;
  logic signed [OPERAND_WIDTH-1:0]   b_den;

  modport source (output valid, req_type, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, req_type, a_num, a_den, b_num, b_den, output ready);
endinterface

// ===== rtl/core/rau_res_if.sv =====
// Result channel of the rational arithmetic unit: reduced fraction and flags.
// Depends on rau_pkg for the result width.
interface rau_res_if;
  logic                             valid;
  logic                             ready;
  logic signed [rau_pkg::RES_W-1:0] res_num;
  logic signed [rau_pkg::RES_W-1:0] res_den;
  logic                             is_equal;
  logic                             zero_gcd_error;

  modport source (output valid, res_num, res_den, is_equal, zero_gcd_error, input ready);
  modport sink   (input valid, res_num, res_den, is_equal, zero_gcd_error, output ready);
endinterface

// ===== rtl/core/rational_arithmetic_unit.sv =====
// Rational arithmetic unit: add, subtract, multiply, divide, compare of fractions.
// Uses rau_pkg, rau_req_if and rau_res_if.
//
// Usage: one request beat on req carries an opcode and two fractions a and b.
// The unit answers with exactly one beat on res: the fraction reduced by its gcd
// (Euclid, truncating remainder), for compare the equality flag; else zero parts.
// Raw parts of add, subtract, multiply and divide come from one shared signed
// multiplier, two or three products, one per cycle. Every remainder and every
// exact division runs on one shared 64-bit restoring divider that retires one
// bit per cycle. Compare reduces two pairs, a and b, one after the other.
// req.ready is high only while the unit is idle; one item is worked at a time.
// The result waits in an output register; a stalled receiver holds it and
// the unit finishes its next item only once that register is free.
// Reset (rst, synchronous) returns the sequencer to idle and drops any result.
module rational_arithmetic_unit #(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  rau_req_if.sink   req,
  rau_res_if.source res
);
  import rau_pkg::*;

  localparam int W = OPERAND_WIDTH;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MUL  = 9'b000000010,
    S_LOAD = 9'b000000100,
    S_GCD  = 9'b000001000,
    S_REM  = 9'b000010000,
    S_DIVN = 9'b000100000,
    S_DIVD = 9'b001000000,
    S_FIN  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t state;
  logic [OP_W-1:0] op;
  logic signed [W-1:0] an, ad, bn, bd;
  logic [1:0] mcnt;
  logic phase, err;
  logic signed [RAW_W-1:0] n, d, x, y, sa_n, sa_d;

  logic [RAW_W-1:0] dq, dr, dv;
  logic [CNT_W-1:0] dcnt;
  logic nq, nr;

  logic signed [W-1:0] ma, mb;
  logic signed [2*W-1:0] prod;
  logic signed [RAW_W-1:0] pext;
  logic addsub, mlast;

  logic [RAW_W:0] dt;
  logic dge;
  logic [RAW_W-1:0] dr_step, q_step;
  logic signed [RAW_W-1:0] q_s, r_s;

  assign addsub = (op == OP_ADD) || (op == OP_SUB);
  assign mlast  = addsub ? (mcnt == 2'd2) : (mcnt == 2'd1);

  always_comb begin
    ma = an;
    mb = bd;
    case (mcnt)
      2'd0: begin
        ma = an;
        mb = (op == OP_MUL) ? bn : bd;
      end
      2'd1: begin
        if (addsub) begin
          ma = bn;
          mb = ad;
        end else begin
          ma = ad;
          mb = (op == OP_MUL) ? bd : bn;
        end
      end
      default: begin
        ma = ad;
        mb = bd;
      end
    endcase
  end

  assign prod = ma * mb;
  assign pext = RAW_W'(prod);

  assign dt      = {dr, dq[RAW_W-1]};
  assign dge     = dt >= {1'b0, dv};
  assign dr_step = dge ? RAW_W'(dt - {1'b0, dv}) : dt[RAW_W-1:0];
  assign q_step  = {dq[RAW_W-2:0], dge};
  assign q_s     = nq ? -q_step : q_step;
  assign r_s     = nr ? -dr_step : dr_step;

  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res.valid <= 1'b0;
      phase     <= 1'b0;
      err       <= 1'b0;
      mcnt      <= '0;
      dcnt      <= '0;
    end else begin
      if (res.valid && res.ready && state != S_OUT) begin
        res.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op    <= req.req_type;
            an    <= req.a_num;
            ad    <= req.a_den;
            bn    <= req.b_num;
            bd    <= req.b_den;
            phase <= 1'b0;
            err   <= 1'b0;
            mcnt  <= '0;
            if (req.req_type == OP_CMP) begin
              n     <= RAW_W'(req.a_num);
              d     <= RAW_W'(req.a_den);
              state <= S_LOAD;
            end else if (req.req_type > OP_CMP) begin
              n     <= '0;
              d     <= '0;
              state <= S_FIN;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          if (mcnt == 2'd0) begin
            n <= pext;
          end else if (addsub && mcnt == 2'd1) begin
            n <= (op == OP_SUB) ? n - pext : n + pext;
          end else begin
            d <= pext;
          end
          mcnt <= mcnt + 2'd1;
          if (mlast) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          x     <= n;
          y     <= d;
          state <= S_GCD;
        end
        S_GCD: begin
          dr   <= '0;
          dcnt <= '0;
          if (y == '0) begin
            if (x == '0) begin
              err   <= 1'b1;
              state <= S_FIN;
            end else begin
              dq    <= n[RAW_W-1] ? -n : n;
              dv    <= x[RAW_W-1] ? -x : x;
              nq    <= n[RAW_W-1] ^ x[RAW_W-1];
              nr    <= n[RAW_W-1];
              state <= S_DIVN;
            end
          end else begin
            dq    <= x[RAW_W-1] ? -x : x;
            dv    <= y[RAW_W-1] ? -y : y;
            nq    <= x[RAW_W-1] ^ y[RAW_W-1];
            nr    <= x[RAW_W-1];
            state <= S_REM;
          end
        end
        S_REM, S_DIVN, S_DIVD: begin
          if (dcnt == CNT_W'(RAW_W - 1)) begin
            dr   <= '0;
            dcnt <= '0;
            case (state)
              S_REM: begin
                x     <= y;
                y     <= r_s;
                state <= S_GCD;
              end
              S_DIVN: begin
                n     <= q_s;
                dq    <= d[RAW_W-1] ? -d : d;
                nq    <= d[RAW_W-1] ^ x[RAW_W-1];
                nr    <= d[RAW_W-1];
                state <= S_DIVD;
              end
              default: begin
                d     <= q_s;
                state <= S_FIN;
              end
            endcase
          end else begin
            dq   <= q_step;
            dr   <= dr_step;
            dcnt <= dcnt + 1'b1;
          end
        end
        S_FIN: begin
          if (op == OP_CMP && !phase) begin
            sa_n  <= n;
            sa_d  <= d;
            n     <= RAW_W'(bn);
            d     <= RAW_W'(bd);
            phase <= 1'b1;
            state <= S_LOAD;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!res.valid || res.ready) begin
            res.valid          <= 1'b1;
            res.res_num        <= (op == OP_CMP) ? '0 : n[RES_W-1:0];
            res.res_den        <= (op == OP_CMP) ? '0 : d[RES_W-1:0];
            res.is_equal       <= (op == OP_CMP) && (sa_n == n) && (sa_d == d);
            res.zero_gcd_error <= err;
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/rau_checker.sv =====
// Port-level checks for the rational arithmetic unit, attached by bind.
// Depends on rau_pkg for the result width.
module rau_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic [rau_pkg::RES_W-1:0]    res_num,
  input logic [rau_pkg::RES_W-1:0]    res_den,
  input logic                         is_equal
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_num) && $stable(res_den))
    else $error("result dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  a_equal_zero_parts: assert property (@(posedge clk) disable iff (rst)
    res_valid && is_equal |-> res_num == '0 && res_den == '0)
    else $error("compare result carries nonzero fraction");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !res_valid && req_ready)
    else $error("reset did not clear the result");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_num   (res.res_num),
  .res_den   (res.res_den),
  .is_equal  (res.is_equal)
);

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for rational_arithmetic_unit: directed rows, then random fractions.
// Each beat is checked against a typed result or an in-bench model of the gcd reduction.
// Needs rau_pkg, rau_req_if and rau_res_if.
module tb_top;
  import rau_pkg::*;

  localparam int W          = OPERAND_WIDTH_DEF;
  localparam int RAND_ITEMS = 1130;
  localparam int PHASES     = 4;
  localparam int HOLD_LEN   = 3000;
  localparam int WDOG_LIMIT = 60000;

  typedef struct packed {
    logic [RES_W-1:0] num;
    logic [RES_W-1:0] den;
    logic             eq;
    logic             err;
  } frac_res_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [W-1:0]    an;
    logic [W-1:0]    ad;
    logic [W-1:0]    bn;
    logic [W-1:0]    bd;
  } frac_req_t;

  typedef struct {
    frac_req_t req;
    bit        typed;
    frac_res_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rau_req_if #(.OPERAND_WIDTH(W)) req_if();
  rau_res_if res_if();

  rational_arithmetic_unit #(.OPERAND_WIDTH(W)) uut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .res(res_if)
  );

  always #5 clk = ~clk;

  frac_res_t pending_q[$];
  int        errors = 0;
  int        beats_in = 0;
  int        beats_out = 0;
  int        op_count[8];
  int        src_idle_pct = 0;
  int        snk_stall_pct = 0;
  int        hold_reqs = 0;
  int        hold_seen = 0;
  int        hold_cnt = 0;
  int        idle_cycles = 0;

  function automatic longint euclid_gcd(longint x, longint y);
    longint t;
    while (y != 0) begin
      t = (y == -1) ? 64'sd0 : x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic longint exact_quo(longint x, longint y);
    return (y == -1) ? -x : x / y;
  endfunction

  function automatic bit reduce_frac(ref longint n, ref longint d);
    longint g;
    g = euclid_gcd(n, d);
    if (g == 0) return 1'b1;
    n = exact_quo(n, g);
    d = exact_quo(d, g);
    return 1'b0;
  endfunction

  function automatic frac_res_t predict_fraction(frac_req_t r);
    frac_res_t o;
    longint an, ad, bn, bd, rn, rd;
    bit ea, eb;
    an = longint'(signed'(r.an));
    ad = longint'(signed'(r.ad));
    bn = longint'(signed'(r.bn));
    bd = longint'(signed'(r.bd));
    rn = 0;
    rd = 0;
    o = '0;
    case (r.op)
      OP_ADD: begin
        rn = an * bd + bn * ad;
        rd = ad * bd;
        o.err = reduce_frac(rn, rd);
      end
      OP_SUB: begin
        rn = an * bd - bn * ad;
        rd = ad * bd;
        o.err = reduce_frac(rn, rd);
      end
      OP_MUL: begin
        rn = an * bn;
        rd = ad * bd;
        o.err = reduce_frac(rn, rd);
      end
      OP_DIV: begin
        rn = an * bd;
        rd = ad * bn;
        o.err = reduce_frac(rn, rd);
      end
      OP_CMP: begin
        ea = reduce_frac(an, ad);
        eb = reduce_frac(bn, bd);
        o.err = ea | eb;
        o.eq = (an == bn) && (ad == bd);
      end
      default: ;
    endcase
    o.num = rn[RES_W-1:0];
    o.den = rd[RES_W-1:0];
    return o;
  endfunction

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    $display("[%0t] beat %0d: %s got %0h want %0h", $time, beats_out, field, got, want);
    errors++;
  endtask

  // response side: check, stall, long hold-off
  always @(posedge clk) begin
    frac_res_t want;
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        beats_out++;
        if (pending_q.size() == 0) begin
          $display("[%0t] unexpected result beat", $time);
          errors++;
        end else begin
          want = pending_q.pop_front();
          if (res_if.res_num !== want.num)
            report("res_num", 64'(unsigned'(res_if.res_num)), 64'(want.num));
          if (res_if.res_den !== want.den)
            report("res_den", 64'(unsigned'(res_if.res_den)), 64'(want.den));
          if (res_if.is_equal !== want.eq)
            report("is_equal", 64'(res_if.is_equal), 64'(want.eq));
          if (res_if.zero_gcd_error !== want.err)
            report("zero_gcd_error", 64'(res_if.zero_gcd_error), 64'(want.err));
        end
      end
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_cnt = HOLD_LEN;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles = 0;
    end else if (++idle_cycles >= WDOG_LIMIT) begin
      $display("timeout: no beat for %0d cycles", WDOG_LIMIT);
      $display("rational_arithmetic_unit: mismatch");
      $finish;
    end
  end

  task automatic send(frac_req_t r, bit typed, frac_res_t typed_res);
    req_if.valid    <= 1'b1;
    req_if.req_type <= r.op;
    req_if.a_num    <= r.an;
    req_if.a_den    <= r.ad;
    req_if.b_num    <= r.bn;
    req_if.b_den    <= r.bd;
    do @(posedge clk); while (!req_if.ready);
    pending_q.push_back(typed ? typed_res : predict_fraction(r));
    op_count[r.op]++;
    beats_in++;
    if ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
  endtask

  function automatic logic [W-1:0] rand_part();
    if ($urandom_range(9) < 8) return W'($signed($urandom_range(40)) - 20);
    return W'($urandom());
  endfunction

  function automatic frac_req_t rand_req();
    frac_req_t r;
    int k;
    k = $urandom_range(19);
    r.op = (k < 19) ? OP_W'(k % 5) : OP_W'($urandom_range(5, 7));
    r.an = rand_part();
    r.ad = rand_part();
    r.bn = rand_part();
    r.bd = rand_part();
    return r;
  endfunction

  localparam logic [W-1:0] MAXP = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] ONE  = W'(1);
  localparam logic [W-1:0] TWO  = W'(2);
  localparam logic [W-1:0] NONE = '1;

  row_t rows[] = '{
    '{'{OP_ADD, ONE, TWO, ONE, TWO}, 1'b1, '{33'd1, 33'd1, 1'b0, 1'b0}},
    '{'{OP_SUB, ONE, TWO, ONE, TWO}, 1'b1, '{33'd0, 33'd1, 1'b0, 1'b0}},
    '{'{OP_MUL, '0, ONE, '0, '0}, 1'b1, '{33'd0, 33'd0, 1'b0, 1'b1}},
    '{'{OP_CMP, ONE, TWO, TWO, W'(4)}, 1'b1, '{33'd0, 33'd0, 1'b1, 1'b0}},
    '{'{OP_CMP, '0, '0, '0, '0}, 1'b1, '{33'd0, 33'd0, 1'b1, 1'b1}},
    '{'{3'd5, MAXP, ONE, ONE, ONE}, 1'b1, '{33'd0, 33'd0, 1'b0, 1'b0}},
    '{'{3'd6, ONE, ONE, ONE, ONE}, 1'b1, '{33'd0, 33'd0, 1'b0, 1'b0}},
    '{'{3'd7, MINN, MINN, MINN, MINN}, 1'b1, '{33'd0, 33'd0, 1'b0, 1'b0}},
    '{'{OP_ADD, MAXP, MAXP, MAXP, MAXP}, 1'b0, '0},
    '{'{OP_ADD, MINN, ONE, MINN, ONE}, 1'b0, '0},
    '{'{OP_SUB, MINN, MAXP, MAXP, MINN}, 1'b0, '0},
    '{'{OP_SUB, NONE, TWO, ONE, NONE}, 1'b0, '0},
    '{'{OP_MUL, MINN, MINN, MINN, NONE}, 1'b0, '0},
    '{'{OP_MUL, MAXP, NONE, MINN, MAXP}, 1'b0, '0},
    '{'{OP_DIV, W'(6), W'(9), W'(4), W'(3)}, 1'b0, '0},
    '{'{OP_DIV, ONE, ONE, '0, ONE}, 1'b0, '0},
    '{'{OP_DIV, MINN, NONE, MINN, NONE}, 1'b0, '0},
    '{'{OP_DIV, W'(-7), W'(3), W'(5), W'(-2)}, 1'b0, '0},
    '{'{OP_CMP, W'(-3), W'(6), W'(1), W'(-2)}, 1'b0, '0},
    '{'{OP_CMP, MAXP, MINN, MINN, MAXP}, 1'b0, '0},
    '{'{OP_CMP, ONE, '0, W'(5), '0}, 1'b0, '0},
    '{'{OP_ADD, '0, W'(7), '0, W'(-3)}, 1'b0, '0}
  };

  initial begin
    int p;
    req_if.valid    = 1'b0;
    req_if.req_type = OP_ADD;
    req_if.a_num    = '0;
    req_if.a_den    = '0;
    req_if.b_num    = '0;
    req_if.b_den    = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send(rows[i].req, rows[i].typed, rows[i].res);
    req_if.valid <= 1'b0;
    wait (pending_q.size() == 0);

    for (p = 0; p < PHASES; p++) begin
      src_idle_pct  = (p == 1 || p == 3) ? 56 : 0;
      snk_stall_pct = (p == 2 || p == 3) ? 56 : 0;
      if (p == 3) src_idle_pct = 32;
      if (p == 3) snk_stall_pct = 32;
      if (p == 2) hold_reqs++;
      for (int n = 0; n < RAND_ITEMS / PHASES; n++) send(rand_req(), 1'b0, '0);
      req_if.valid <= 1'b0;
      wait (pending_q.size() == 0);
      @(posedge clk);
    end

    repeat (100) @(posedge clk);
    $display("covered %0d requests / %0d results: add %0d sub %0d mul %0d div %0d cmp %0d",
             beats_in, beats_out, op_count[0], op_count[1], op_count[2], op_count[3],
             op_count[4]);
    $display("undefined opcodes %0d; idle, stall, long hold-off phases run; errors %0d",
             op_count[5] + op_count[6] + op_count[7], errors);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("rational_arithmetic_unit: match");
    end else begin
      $display("rational_arithmetic_unit: mismatch");
    end
    $finish;
  end
endmodule
